// File: sv/fm_phase_modulation_oscillator_core_defines.svh
// assertion macros for the fm oscillator core
// expects clk_i and rst_ni in the scope of each use
`ifndef FM_PHASE_MODULATION_OSCILLATOR_CORE_DEFINES_SVH
`define FM_PHASE_MODULATION_OSCILLATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FMO_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fmo assertion failed");
`define FMO_ASSERT_NEVER(label, cond) \
  `FMO_ASSERT(label, !(cond))
`else
`define FMO_ASSERT(label, prop)
`define FMO_ASSERT_NEVER(label, cond)
`endif

`endif

// File: sv/fmo_pkg.sv
// shared types, register indexes and sine table function for the fm oscillator
// no dependencies
`timescale 1ns / 1ps

package fmo_pkg;

  localparam int PHASE_W  = 32;
  localparam int DEPTH_W  = 20;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int OFFSET_W = 16;
  localparam int FRAC_SHIFT = 15;
  localparam int PROD_W = DEPTH_W + 1 + SAMPLE_W;
  localparam real PI_HALF = 1.5707963267948966;
  localparam real FULL_SCALE = 32767.0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_INC = 2'd0,
    REG_MOD_INC     = 2'd1,
    REG_MOD_DEPTH   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic restart;
  } tick_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
  } sample_t;

  // round(32767 * sin(2 pi k / 2^tb)) built from the first quarter wave
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(int k, int tb);
    int  qs;
    int  q;
    int  j;
    int  r;
    real step;
    real v;
    qs = 1 << (tb - 2);
    q = (k >> (tb - 2)) & 3;
    j = k & (qs - 1);
    if (q[0]) begin
      j = qs - j;
    end
    step = PI_HALF * (2.0 ** (-(tb - 2)));
    v = FULL_SCALE * $sin(step * j);
    r = $rtoi(v + 0.5);
    if (q[1]) begin
      r = -r;
    end
    return SAMPLE_W'(r);
  endfunction

endpackage

// File: sv/fmo_stream_if.sv
// valid/ready stream channel carrying one payload struct
// payload type comes from fmo_pkg
`timescale 1ns / 1ps

interface fmo_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/fm_phase_modulation_oscillator_core.sv
// two-operator phase modulation oscillator, top level
// depends on fmo_pkg, fmo_stream_if, fmo_sine_rom and the assertion macro header
//
//   channel   | dir | payload            | request means
//   tick_i    | in  | restart (1 bit)    | make one sample, optionally zero phases first
//   sample_o  | out | sample (16 bit s)  | one sample per tick request
//   cfg_*     | in  | idx 2 bit, data 32 | register write, no handshake
//
// one request per clock unless sample_o stalls; sample valid in the last stage
// stages: modulator rom read, depth multiply, carrier add plus rom read
// each stage loads when empty or when the next stage moves, so bubbles collapse
// a stall on sample_o backs up stage by stage before tick_i.ready drops
// reset clears registers, phases and stage valids; no clearing pass
`timescale 1ns / 1ps
`include "fm_phase_modulation_oscillator_core_defines.svh"

module fm_phase_modulation_oscillator_core #(
  parameter int TABLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fmo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fmo_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  fmo_stream_if.sink                        tick_i,
  fmo_stream_if.source                      sample_o
);

  logic [fmo_pkg::PHASE_W-1:0] car_inc_q;
  logic [fmo_pkg::PHASE_W-1:0] mod_inc_q;
  logic [fmo_pkg::DEPTH_W-1:0] depth_q;
  logic [fmo_pkg::PHASE_W-1:0] car_ph_q;
  logic [fmo_pkg::PHASE_W-1:0] mod_ph_q;
  logic [fmo_pkg::PHASE_W-1:0] car_ph_d;
  logic [fmo_pkg::PHASE_W-1:0] mod_ph_d;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic acc;

  logic [fmo_pkg::PHASE_W-1:0]          cph1_q;
  logic [fmo_pkg::PHASE_W-1:0]          cph2_q;
  logic [fmo_pkg::OFFSET_W-1:0]         off2_q;
  logic signed [fmo_pkg::SAMPLE_W-1:0]  msin1;
  logic signed [fmo_pkg::SAMPLE_W-1:0]  sample3;
  logic signed [fmo_pkg::PROD_W-1:0]    prod;
  logic [fmo_pkg::PHASE_W-1:0]          eff;

  assign en3 = !v3_q || sample_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign tick_i.ready = en1;
  assign acc = tick_i.valid && en1;

  // phases after the optional restart
  assign car_ph_d = tick_i.payload.restart ? '0 : car_ph_q;
  assign mod_ph_d = tick_i.payload.restart ? '0 : mod_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_inc_q <= '0;
      mod_inc_q <= '0;
      depth_q   <= '0;
    end else if (cfg_we_i) begin
      case (fmo_pkg::reg_idx_e'(cfg_idx_i))
        fmo_pkg::REG_CARRIER_INC: car_inc_q <= cfg_wdata_i[fmo_pkg::PHASE_W-1:0];
        fmo_pkg::REG_MOD_INC:     mod_inc_q <= cfg_wdata_i[fmo_pkg::PHASE_W-1:0];
        fmo_pkg::REG_MOD_DEPTH:   depth_q   <= cfg_wdata_i[fmo_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_ph_q <= '0;
      mod_ph_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      if (acc) begin
        car_ph_q <= car_ph_d + car_inc_q;
        mod_ph_q <= mod_ph_d + mod_inc_q;
      end
      if (en1) begin
        v1_q <= acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  fmo_sine_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_mod_rom (
    .clk_i (clk_i),
    .en_i  (acc),
    .addr_i(mod_ph_d[fmo_pkg::PHASE_W-1 -: TABLE_BITS]),
    .data_o(msin1)
  );

  assign prod = $signed({1'b0, depth_q}) * msin1;
  assign eff  = cph2_q + {off2_q, {(fmo_pkg::PHASE_W - fmo_pkg::OFFSET_W){1'b0}}};

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cph1_q <= car_ph_d;
    end
    if (en2) begin
      cph2_q <= cph1_q;
      off2_q <= prod[fmo_pkg::FRAC_SHIFT + fmo_pkg::OFFSET_W - 1 : fmo_pkg::FRAC_SHIFT];
    end
  end

  fmo_sine_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_car_rom (
    .clk_i (clk_i),
    .en_i  (en3),
    .addr_i(eff[fmo_pkg::PHASE_W-1 -: TABLE_BITS]),
    .data_o(sample3)
  );

  assign sample_o.valid = v3_q;
  assign sample_o.payload.sample = sample3;

  `FMO_ASSERT(a_restart_car, (acc && tick_i.payload.restart) |=> car_ph_q == $past(car_inc_q))
  `FMO_ASSERT(a_restart_mod, (acc && tick_i.payload.restart) |=> mod_ph_q == $past(mod_inc_q))
  `FMO_ASSERT(a_ph_step, (acc && !tick_i.payload.restart) |=> car_ph_q == $past(car_ph_q + car_inc_q))
  `FMO_ASSERT(a_phase_hold, !acc |=> ($stable(car_ph_q) && $stable(mod_ph_q)))
  `FMO_ASSERT(a_stall_full, !tick_i.ready |-> (v1_q && v2_q && v3_q && !sample_o.ready))
  `FMO_ASSERT_NEVER(a_sample_range, v3_q && (sample3 == -16'sd32768))

endmodule

// File: sv/fmo_sine_rom.sv
// full-wave sine rom with registered read, contents fixed at elaboration
// depends on fmo_pkg
`timescale 1ns / 1ps

module fmo_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [TABLE_BITS-1:0]                 addr_i,
  output logic signed [fmo_pkg::SAMPLE_W-1:0]   data_o
);

  localparam int Depth = 1 << TABLE_BITS;

  logic signed [fmo_pkg::SAMPLE_W-1:0] rom_w [Depth];
  logic signed [fmo_pkg::SAMPLE_W-1:0] data_q;

  for (genvar k = 0; k < Depth; k++) begin : g_rom
    assign rom_w[k] = fmo_pkg::sine_entry(k, TABLE_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: verif/fmo_sample_checker.sv
// sample checker for the fm oscillator core: watches config writes and both channels,
// predicts each sample from its own phase accumulators and sine lookup, counts mismatches
// depends on fmo_pkg and fmo_stream_if
`timescale 1ns / 1ps

module fmo_sample_checker #(
  parameter int TABLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fmo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fmo_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fmo_stream_if                          tick_mon,
  fmo_stream_if                          sample_mon,
  output int                             errors_o,
  output int                             pending_o
);

  localparam int  LUT_SIZE = 1 << TABLE_BITS;
  localparam int  QTR = LUT_SIZE / 4;
  localparam real QUARTER_TURN_RAD = 1.5707963267948966;
  localparam int  FIFO_DEPTH = 8;
  localparam int  PTR_W = 3;

  logic signed [fmo_pkg::SAMPLE_W-1:0] sine_lut [LUT_SIZE];
  logic [fmo_pkg::PHASE_W-1:0]         carrier_phase;
  logic [fmo_pkg::PHASE_W-1:0]         modulator_phase;
  logic [fmo_pkg::PHASE_W-1:0]         carrier_inc;
  logic [fmo_pkg::PHASE_W-1:0]         modulator_inc;
  logic [fmo_pkg::DEPTH_W-1:0]         depth;
  logic signed [fmo_pkg::SAMPLE_W-1:0] exp_fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]                    wr_ptr;
  logic [PTR_W-1:0]                    rd_ptr;
  int                                  fill;

  // quarter wave rounded to nearest, mirrored into the full wave
  initial begin
    int qv [QTR+1];
    int j;
    int v;
    for (int k = 0; k <= QTR; k++) begin
      qv[k] = $rtoi($floor(32767.0 * $sin(QUARTER_TURN_RAD * k / QTR) + 0.5));
    end
    for (int k = 0; k < LUT_SIZE; k++) begin
      j = k % QTR;
      v = (((k / QTR) % 2) == 1) ? qv[QTR - j] : qv[j];
      sine_lut[k] = (k >= 2 * QTR) ? fmo_pkg::SAMPLE_W'(-v) : fmo_pkg::SAMPLE_W'(v);
    end
  end

  function automatic logic signed [fmo_pkg::SAMPLE_W-1:0] modulated_sample(
    input logic [fmo_pkg::PHASE_W-1:0] cp,
    input logic [fmo_pkg::PHASE_W-1:0] mp
  );
    logic signed [fmo_pkg::SAMPLE_W-1:0] m;
    logic signed [fmo_pkg::PROD_W-1:0]   prod;
    logic signed [fmo_pkg::PROD_W-1:0]   ofs;
    logic [fmo_pkg::PHASE_W-1:0]         eff;
    m = sine_lut[mp[fmo_pkg::PHASE_W-1 -: TABLE_BITS]];
    prod = $signed({1'b0, depth}) * m;
    ofs = prod >>> fmo_pkg::FRAC_SHIFT;
    eff = cp + {ofs[fmo_pkg::OFFSET_W-1:0], 16'h0000};
    return sine_lut[eff[fmo_pkg::PHASE_W-1 -: TABLE_BITS]];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] sample mismatch: %s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [fmo_pkg::SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      carrier_phase = '0;
      modulator_phase = '0;
      carrier_inc = '0;
      modulator_inc = '0;
      depth = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      fill = 0;
      pending_o = 0;
    end else begin
      if (sample_mon.valid && sample_mon.ready) begin
        if (fill == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", sample_mon.payload.sample));
        end else begin
          want = exp_fifo[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          fill--;
          if (sample_mon.payload.sample !== want) begin
            report_mismatch($sformatf("got %0d, want %0d", sample_mon.payload.sample, want));
          end
        end
      end
      if (tick_mon.valid && tick_mon.ready) begin
        if (tick_mon.payload.restart) begin
          carrier_phase = '0;
          modulator_phase = '0;
        end
        if (fill == FIFO_DEPTH) begin
          report_mismatch("too many requests in flight");
        end else begin
          exp_fifo[wr_ptr] = modulated_sample(carrier_phase, modulator_phase);
          wr_ptr = wr_ptr + 1'b1;
          fill++;
        end
        carrier_phase = carrier_phase + carrier_inc;
        modulator_phase = modulator_phase + modulator_inc;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fmo_pkg::REG_CARRIER_INC: begin
            carrier_inc = cfg_wdata_i;
          end
          fmo_pkg::REG_MOD_INC: begin
            modulator_inc = cfg_wdata_i;
          end
          fmo_pkg::REG_MOD_DEPTH: begin
            depth = cfg_wdata_i[fmo_pkg::DEPTH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      pending_o = fill;
    end
  end

endmodule

// File: verif/tb_top.sv
// top testbench for the fm oscillator core: clock, reset, register writes, tick
// requests with random gaps and sample back-pressure, watchdog and verdict
// depends on fmo_pkg, fmo_stream_if, fmo_sample_checker and the core
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_BITS = 10;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam logic [fmo_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [fmo_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [fmo_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             tx_idle_pct;
  int                             rx_idle_pct;
  int                             errors;
  int                             pending;
  int                             idle_cycles;

  fmo_stream_if #(.payload_t(fmo_pkg::tick_t))   tick_if ();
  fmo_stream_if #(.payload_t(fmo_pkg::sample_t)) sample_if ();

  fm_phase_modulation_oscillator_core #(
    .TABLE_BITS(TABLE_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .tick_i     (tick_if.sink),
    .sample_o   (sample_if.source)
  );

  fmo_sample_checker #(
    .TABLE_BITS(TABLE_BITS)
  ) u_sample_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .tick_mon   (tick_if),
    .sample_mon (sample_if),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // sample back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.ready <= 1'b0;
    end else begin
      sample_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (sample_if.valid && sample_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] random_increment();
    case ($urandom_range(3))
      0: return $urandom_range(255);
      1: return $urandom_range(32'h00FF_FFFF);
      2: return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic configure(
    input logic [31:0] carrier,
    input logic [31:0] modulator,
    input logic [31:0] depth_word,
    input bit          poke_unused
  );
    cfg_we <= 1'b1;
    cfg_idx <= fmo_pkg::REG_CARRIER_INC;
    cfg_wdata <= carrier;
    @(posedge clk_i);
    cfg_idx <= fmo_pkg::REG_MOD_INC;
    cfg_wdata <= modulator;
    @(posedge clk_i);
    cfg_idx <= fmo_pkg::REG_MOD_DEPTH;
    cfg_wdata <= depth_word;
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_idx <= REG_UNUSED;
      cfg_wdata <= $urandom();
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_tick(input logic restart);
    logic took;
    while ($urandom_range(99) < tx_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.payload.restart <= restart;
    do begin
      @(negedge clk_i);
      took = tick_if.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // lets every outstanding sample come back before registers change
  task automatic drain_pipeline();
    tick_if.valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] dw;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= fmo_pkg::REG_CARRIER_INC;
    cfg_wdata <= '0;
    tick_if.valid <= 1'b0;
    tick_if.payload <= '0;
    tx_idle_pct = 18;
    rx_idle_pct = 71;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values, restart on zero phases
    for (int i = 0; i < 3; i++) begin
      send_tick(i == 1);
    end
    drain_pipeline();

    // full-scale increments wrap every tick, junk above the depth width
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hABCF_FFFF, 1'b1);
    for (int i = 0; i < 6; i++) begin
      send_tick(i == 3);
    end
    drain_pipeline();

    // quarter and half turn steps with one full turn of depth
    configure(32'h4000_0000, 32'h8000_0000, 32'h0001_0000, 1'b0);
    for (int i = 0; i < 5; i++) begin
      send_tick(i == 4);
    end
    drain_pipeline();

    configure(32'h0000_0001, 32'h0000_0000, 32'h0008_0000, 1'b1);
    for (int i = 0; i < 3; i++) begin
      send_tick(i == 1);
    end
    drain_pipeline();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) begin
        tx_idle_pct = 71;
        rx_idle_pct = 18;
      end
      if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      dw = $urandom();
      if ($urandom_range(3) == 0) begin
        dw[fmo_pkg::DEPTH_W-1:0] = ($urandom_range(1) != 0) ? 20'hFFFFF : 20'h00000;
      end
      configure(random_increment(), random_increment(), dw, $urandom_range(3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_tick($urandom_range(15) == 0);
      end
      drain_pipeline();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/fmo_pkg.sv
sv/fmo_stream_if.sv
sv/fmo_sine_rom.sv
sv/fm_phase_modulation_oscillator_core.sv
verif/fmo_sample_checker.sv
verif/tb_top.sv
